FILE: src/tsce_pkg.sv
// Shared types, constants and the microcode program of the Taylor series core.
// Has no dependencies; every other file of the core imports it.
package tsce_pkg;

   // Number format and series limits.
   localparam int FRAC_BITS = 28;
   localparam int MAX_TERMS = 64;
   localparam int X_W       = 32;
   localparam int SUM_W     = 48;
   localparam int MAG_W     = 47;
   localparam int IDX_W     = 7;
   localparam int PROD_W    = 64;

   // Divider geometry: a 48-bit dividend, a 12-bit divisor, four quotient bits a cycle.
   localparam int DIVIDEND_W     = 48;
   localparam int DIVISOR_W      = 12;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // 2 pi in Q32, rounded to FRAC_BITS fraction bits.
   localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
   localparam longint unsigned TWO_PI_FULL =
      (((TWO_PI_Q32 << 1) >> (32 - FRAC_BITS)) + 64'd1) >> 1;
   localparam logic [X_W-1:0] TWO_PI = X_W'(TWO_PI_FULL);

   localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};
   localparam logic [MAG_W-1:0]  ONE_Q      = MAG_W'(1) << FRAC_BITS;
   localparam logic [PROD_W+15:0] ROUND_HALF = (PROD_W+16)'(1) << (FRAC_BITS - 1);

   // Function select codes.
   localparam logic [1:0] FUNC_SIN = 2'd0;
   localparam logic [1:0] FUNC_COS = 2'd1;
   localparam logic [1:0] FUNC_EXP = 2'd2;
   localparam logic [1:0] FUNC_BAD = 2'd3;

   // Datapath operations that one control word can issue.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_NOP,
      OP_ACCUM,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_FIN,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_FIN
   } dp_op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_BAD_TYPE,
      COND_LAST,
      COND_EXP,
      COND_DIV_MORE
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      upc_type   target;
   } ucode_word_type;

   typedef struct packed {
      logic bad_type;
      logic last;
      logic is_exp;
      logic div_more;
   } dp_status_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   // Program addresses.
   localparam upc_type STEP_IDLE     = 4'd0;
   localparam upc_type STEP_CHECK    = 4'd1;
   localparam upc_type STEP_ACCUM    = 4'd2;
   localparam upc_type STEP_MUL1_LO  = 4'd3;
   localparam upc_type STEP_MUL1_HI  = 4'd4;
   localparam upc_type STEP_MUL1_FIN = 4'd5;
   localparam upc_type STEP_MUL2_LO  = 4'd6;
   localparam upc_type STEP_MUL2_HI  = 4'd7;
   localparam upc_type STEP_MUL2_FIN = 4'd8;
   localparam upc_type STEP_DIV_INIT = 4'd9;
   localparam upc_type STEP_DIV_LOOP = 4'd10;
   localparam upc_type STEP_DIV_FIN  = 4'd11;

   // The microcode program. A taken condition loads target, otherwise the
   // step counter advances by one.
   function automatic ucode_word_type ucode_rom(input upc_type addr);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (addr)
         STEP_IDLE:     w = '{op: OP_IDLE,     cond: COND_NO_START, target: STEP_IDLE};
         STEP_CHECK:    w = '{op: OP_NOP,      cond: COND_BAD_TYPE, target: STEP_IDLE};
         STEP_ACCUM:    w = '{op: OP_ACCUM,    cond: COND_LAST,     target: STEP_IDLE};
         STEP_MUL1_LO:  w = '{op: OP_MUL_LO,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_MUL1_HI:  w = '{op: OP_MUL_HI,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_MUL1_FIN: w = '{op: OP_MUL_FIN,  cond: COND_EXP,      target: STEP_DIV_INIT};
         STEP_MUL2_LO:  w = '{op: OP_MUL_LO,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_MUL2_HI:  w = '{op: OP_MUL_HI,   cond: COND_NEVER,    target: STEP_IDLE};
         STEP_MUL2_FIN: w = '{op: OP_MUL_FIN,  cond: COND_NEVER,    target: STEP_IDLE};
         STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: STEP_IDLE};
         STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIV_LOOP};
         STEP_DIV_FIN:  w = '{op: OP_DIV_FIN,  cond: COND_ALWAYS,   target: STEP_ACCUM};
         default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: src/tsce_divider.sv
// Iterative restoring divider, four quotient bits per cycle, for the term update.
// Depends on tsce_pkg.
module tsce_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  tsce_pkg::div_ctrl_type            ctrl,
   input  logic [tsce_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [tsce_pkg::DIVISOR_W-1:0]    divisor,
   output logic [tsce_pkg::DIVIDEND_W-1:0]   quotient,
   output logic                              more
);
   import tsce_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;

   logic [DIVISOR_W-1:0]  rem_v;
   logic [DIVIDEND_W-1:0] quo_v;
   logic [DIVISOR_W:0]    trial_v;

   // Four restoring steps; the dividend shifts out of the top of quo while
   // quotient bits shift in at the bottom.
   always_comb begin
      rem_v   = rem_ff;
      quo_v   = quo_ff;
      trial_v = '0;
      for (int j = 0; j < DIV_RADIX_BITS; j++) begin
         trial_v = {rem_v, quo_v[DIVIDEND_W-1]};
         quo_v   = {quo_v[DIVIDEND_W-2:0], 1'b0};
         if (trial_v >= {1'b0, dvs_ff}) begin
            trial_v  = trial_v - {1'b0, dvs_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial_v[DIVISOR_W-1:0];
      end
   end

   // Next values.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (ctrl.init) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
      end else if (ctrl.step) begin
         rem_in = rem_v;
         quo_in = quo_v;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign more     = (cnt_ff != DIV_CNT_W'(DIV_STEPS - 1));

endmodule

FILE: src/tsce_datapath.sv
// Datapath of the Taylor series core: argument fold, shared multiplier, divider,
// saturating accumulator and result registers. Depends on tsce_pkg and tsce_divider.
module tsce_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tsce_pkg::dp_op_type           op,
   input  logic                          start,
   input  logic [1:0]                    req_type,
   input  logic [tsce_pkg::X_W-1:0]      req_x_value,
   input  logic [tsce_pkg::IDX_W-1:0]    num_terms,
   output tsce_pkg::dp_status_type       status,
   output logic                          rsp_valid,
   output logic [tsce_pkg::SUM_W-1:0]    rsp_partial_sum,
   output logic [tsce_pkg::IDX_W-1:0]    rsp_term_index,
   output logic                          rsp_last
);
   import tsce_pkg::*;

   logic [1:0]        type_ff, type_in;
   logic              xneg_ff, xneg_in;
   logic [X_W-1:0]    ax_ff, ax_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_lo_ff, prod_lo_in;
   logic [MAG_W-1:0]  prod_hi_ff, prod_hi_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [X_W-1:0]        ax_abs;
   logic [X_W-1:0]        ax_fold;
   logic [IDX_W-1:0]      n_clamp;
   logic                  is_exp;
   logic [IDX_W-1:0]      step_size;
   logic                  is_last;
   logic [X_W-1:0]        mul_a;
   logic [PROD_W-1:0]     mul_p;
   logic [PROD_W+15:0]    mul_total;
   logic [PROD_W+15:0]    mul_shift;
   logic [MAG_W-1:0]      mul_round;
   logic [SUM_W:0]        acc_wide;
   logic [SUM_W-1:0]      acc_sat;
   logic [IDX_W-1:0]      div_base;
   logic [2*IDX_W:0]      div_prod;
   logic [DIVISOR_W-1:0]  divisor;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] quotient;
   logic                  div_more;
   div_ctrl_type          div_ctrl;

   // Magnitude of the argument; sine and cosine fold it once into [0, 2pi].
   assign ax_abs  = req_x_value[X_W-1] ? (~req_x_value + X_W'(1)) : req_x_value;
   assign ax_fold = ((req_type == FUNC_SIN || req_type == FUNC_COS) && ax_abs > TWO_PI)
                    ? (ax_abs - TWO_PI) : ax_abs;

   // Highest index, held to the range one to MAX_TERMS.
   always_comb begin
      if (num_terms == '0) begin
         n_clamp = IDX_W'(1);
      end else if (num_terms > IDX_W'(MAX_TERMS)) begin
         n_clamp = IDX_W'(MAX_TERMS);
      end else begin
         n_clamp = num_terms;
      end
   end

   assign is_exp    = (type_ff == FUNC_EXP);
   assign step_size = is_exp ? IDX_W'(1) : IDX_W'(2);
   assign is_last   = ({1'b0, idx_ff} + {1'b0, step_size}) > {1'b0, n_ff};

   // Shared multiplier: low 32 bits of the term, then its high bits, times |x|.
   assign mul_a = (op == OP_MUL_HI) ? X_W'(mag_ff[MAG_W-1:32]) : mag_ff[31:0];
   assign mul_p = mul_a * ax_ff;

   // Recombine the partial products, round half up and clamp the magnitude.
   assign mul_total = {1'b0, prod_hi_ff, 32'b0} + {16'b0, prod_lo_ff} + ROUND_HALF;
   assign mul_shift = mul_total >> FRAC_BITS;
   assign mul_round = (mul_shift > (PROD_W+16)'(MAG_MAX)) ? MAG_MAX : mul_shift[MAG_W-1:0];

   // Signed accumulate with saturation to the 48-bit range.
   assign acc_wide = {sum_ff[SUM_W-1], sum_ff} +
                     (neg_ff ? -{2'b00, mag_ff} : {2'b00, mag_ff});
   always_comb begin
      if (acc_wide[SUM_W:SUM_W-1] == 2'b01) begin
         acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (acc_wide[SUM_W:SUM_W-1] == 2'b10) begin
         acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         acc_sat = acc_wide[SUM_W-1:0];
      end
   end

   // Divisor of the new index k: k-1 for the exponential, (k-1)k for sine, (k-2)(k-1) for cosine.
   assign div_base = idx_ff - ((type_ff == FUNC_COS) ? IDX_W'(2) : IDX_W'(1));
   assign div_prod = div_base * ({1'b0, div_base} + (IDX_W+1)'(1));
   assign divisor  = is_exp ? DIVISOR_W'(div_base) : div_prod[DIVISOR_W-1:0];
   assign dividend = {1'b0, mag_ff} + DIVIDEND_W'(divisor >> 1);

   tsce_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .more     (div_more)
   );

   // Operation decode.
   always_comb begin
      type_in      = type_ff;
      xneg_in      = xneg_ff;
      ax_in        = ax_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      prod_lo_in   = prod_lo_ff;
      prod_hi_in   = prod_hi_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      div_ctrl     = '0;
      unique case (op)
         OP_IDLE: begin
            if (start) begin
               type_in = req_type;
               xneg_in = req_x_value[X_W-1];
               ax_in   = ax_fold;
               n_in    = n_clamp;
               idx_in  = IDX_W'(1);
               mag_in  = (req_type == FUNC_SIN) ? MAG_W'(ax_fold) : ONE_Q;
               neg_in  = (req_type == FUNC_SIN) ? req_x_value[X_W-1] : 1'b0;
               sum_in  = '0;
            end
         end
         OP_NOP: begin
         end
         OP_ACCUM: begin
            sum_in       = acc_sat;
            rsp_valid_in = 1'b1;
            rsp_sum_in   = acc_sat;
            rsp_idx_in   = idx_ff;
            rsp_last_in  = is_last;
            idx_in       = idx_ff + step_size;
         end
         OP_MUL_LO: begin
            prod_lo_in = mul_p;
         end
         OP_MUL_HI: begin
            prod_hi_in = mul_p[MAG_W-1:0];
         end
         OP_MUL_FIN: begin
            mag_in = mul_round;
         end
         OP_DIV_INIT: begin
            div_ctrl.init = 1'b1;
            neg_in        = is_exp ? (neg_ff ^ xneg_ff) : ~neg_ff;
         end
         OP_DIV_STEP: begin
            div_ctrl.step = 1'b1;
         end
         OP_DIV_FIN: begin
            mag_in = quotient[MAG_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      xneg_ff     <= xneg_in;
      ax_ff       <= ax_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      sum_ff      <= sum_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Status for the sequencer's jump conditions.
   assign status.bad_type = (type_ff == FUNC_BAD);
   assign status.last     = is_last;
   assign status.is_exp   = is_exp;
   assign status.div_more = div_more;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_partial_sum = rsp_sum_ff;
   assign rsp_term_index  = rsp_idx_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: src/tsce_sequencer.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on tsce_pkg.
module tsce_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  tsce_pkg::dp_status_type    status,
   output tsce_pkg::dp_op_type        op,
   output logic                       busy
);
   import tsce_pkg::*;

   upc_type        upc_ff, upc_in;
   ucode_word_type word;
   logic           taken;

   assign word = ucode_rom(upc_ff);

   // Evaluate the jump condition of the current control word.
   always_comb begin
      unique case (word.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_START: taken = ~start;
         COND_BAD_TYPE: taken = status.bad_type;
         COND_LAST:     taken = status.last;
         COND_EXP:      taken = status.is_exp;
         COND_DIV_MORE: taken = status.div_more;
         default:       taken = 1'b1;
      endcase
   end

   assign upc_in = taken ? word.target : (upc_ff + upc_type'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign op   = word.op;
   assign busy = (upc_ff != STEP_IDLE);

endmodule

FILE: src/taylor_series_sin_cos_exp_core.sv
// Top level of the Taylor series core: num_terms register, sequencer and datapath.
// Depends on tsce_pkg, tsce_sequencer and tsce_datapath.
//
// Evaluates sine, cosine or exponential of a Q3.28 argument by summing the Taylor
// series and emits every partial sum as one beat on rsp_*, the last one marked by
// rsp_last. An argument is taken when start is high and busy low. Each beat is on
// the ports for exactly one cycle with rsp_valid high; the receiver cannot stall.
// The first beat leaves after the check and accumulate steps. Each further beat
// follows a term update: the term is multiplied by |x| twice for sine and cosine
// and once for the exponential, divided, and then accumulated. An argument gives
// ceil(n/2) beats for sine and cosine and n for the exponential, n the clamped
// num_terms. The divider makes four quotient bits a cycle, and the one 32x32
// multiplier is used twice per multiplication. busy is low again in the cycle of
// the last beat. A selector of 3 is taken and gives no beat. num_terms must be
// written only while busy is low; the block itself does not enforce this.
module taylor_series_sin_cos_exp_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [tsce_pkg::X_W-1:0]      req_x_value,
   output logic                          rsp_valid,
   output logic [tsce_pkg::SUM_W-1:0]    rsp_partial_sum,
   output logic [tsce_pkg::IDX_W-1:0]    rsp_term_index,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  logic [tsce_pkg::IDX_W-1:0]    csr_write_data
);
   import tsce_pkg::*;

   localparam logic [IDX_W-1:0] NUM_TERMS_RESET = IDX_W'(10);

   logic [IDX_W-1:0] num_terms_ff, num_terms_in;
   dp_op_type        op;
   dp_status_type    status;

   // Configuration register.
   assign num_terms_in = csr_write_en ? csr_write_data : num_terms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= NUM_TERMS_RESET;
      end else begin
         num_terms_ff <= num_terms_in;
      end
   end

   tsce_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   tsce_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .start           (start),
      .req_type        (req_type),
      .req_x_value     (req_x_value),
      .num_terms       (num_terms_ff),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_partial_sum (rsp_partial_sum),
      .rsp_term_index  (rsp_term_index),
      .rsp_last        (rsp_last)
   );

   // The last beat of an argument frees the block in the same cycle.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy still high on the last beat");

   // A beat that is not the last leaves the block working.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("block idle before the last beat");

   // Beats are spaced by the term update and never come back to back.
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("beats in adjacent cycles");

   // Series indices start at one.
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_term_index != '0)
      else $error("beat with index zero");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Taylor series sine, cosine and exponential core.
// Depends on tsce_pkg and taylor_series_sin_cos_exp_core; it predicts every partial
// sum from its own fixed-point model and checks each result beat in order.
module testbench;
   import tsce_pkg::*;

   localparam int          RESET_CYCLES  = 5;
   localparam int          SETTLE_CYCLES = 30;
   localparam int          FIXED_PHASES  = 7;
   localparam int          PHASES        = 11;
   localparam longint unsigned TWO_PI_Q  =
      (((64'd26986075409 << 1) >> (32 - FRAC_BITS)) + 64'd1) >> 1;
   localparam longint unsigned MAG_LIMIT = (64'd1 << 47) - 64'd1;
   localparam longint          SUM_HI    = (64'sd1 <<< 47) - 64'sd1;
   localparam longint          SUM_LO    = -(64'sd1 <<< 47);
   localparam logic [47:0]     Q_ONE     = 48'h0000_1000_0000;

   // One partial sum as it leaves the block.
   typedef struct {
      logic [SUM_W-1:0] sum;
      logic [IDX_W-1:0] idx;
      logic             last;
   } sum_beat_type;

   // One directed argument; first_sum is checked on the first beat when typed is set.
   typedef struct {
      logic [1:0]       func;
      logic [X_W-1:0]   x;
      bit               typed;
      logic [SUM_W-1:0] first_sum;
   } arg_row_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic [1:0]          req_type       = FUNC_SIN;
   logic [X_W-1:0]      req_x_value    = '0;
   logic                rsp_valid;
   logic [SUM_W-1:0]    rsp_partial_sum;
   logic [IDX_W-1:0]    rsp_term_index;
   logic                rsp_last;
   logic                csr_write_en   = 1'b0;
   logic [IDX_W-1:0]    csr_write_data = '0;

   sum_beat_type        pending_sums[$];
   logic [IDX_W-1:0]    num_terms_cfg  = 7'd10;
   int                  error_count    = 0;

   int unsigned fixed_terms [FIXED_PHASES] = '{1, 2, 3, 64, 0, 127, 65};

   // Extremes, fold boundaries and the unused selector, run at the reset term count.
   arg_row_type directed_args [22] = '{
      '{FUNC_SIN, 32'h0000_0000,         1'b1, 48'h0},
      '{FUNC_COS, 32'h0000_0000,         1'b1, Q_ONE},
      '{FUNC_EXP, 32'h0000_0000,         1'b1, Q_ONE},
      '{FUNC_SIN, 32'h1000_0000,         1'b1, 48'h0000_1000_0000},
      '{FUNC_SIN, 32'hF000_0000,         1'b1, 48'hFFFF_F000_0000},
      '{FUNC_SIN, 32'h7FFF_FFFF,         1'b0, 48'h0},
      '{FUNC_SIN, 32'h8000_0000,         1'b0, 48'h0},
      '{FUNC_COS, 32'h7FFF_FFFF,         1'b1, Q_ONE},
      '{FUNC_COS, 32'h8000_0000,         1'b1, Q_ONE},
      '{FUNC_EXP, 32'h7FFF_FFFF,         1'b1, Q_ONE},
      '{FUNC_EXP, 32'h8000_0000,         1'b1, Q_ONE},
      '{FUNC_SIN, 32'(TWO_PI_Q),         1'b1, 48'(TWO_PI_Q)},
      '{FUNC_SIN, 32'(TWO_PI_Q + 1),     1'b1, 48'h0000_0000_0001},
      '{FUNC_SIN, -32'(TWO_PI_Q + 1),    1'b1, 48'hFFFF_FFFF_FFFF},
      '{FUNC_COS, -32'(TWO_PI_Q),        1'b1, Q_ONE},
      '{FUNC_EXP, 32'h1000_0000,         1'b0, 48'h0},
      '{FUNC_EXP, 32'hF000_0000,         1'b0, 48'h0},
      '{FUNC_EXP, 32'h0000_0001,         1'b0, 48'h0},
      '{FUNC_BAD, 32'h7FFF_FFFF,         1'b0, 48'h0},
      '{FUNC_BAD, 32'h8000_0000,         1'b0, 48'h0},
      '{FUNC_COS, 32'h1000_0000,         1'b0, 48'h0},
      '{FUNC_SIN, 32'hFFFF_FFFF,         1'b1, 48'hFFFF_FFFF_FFFF}
   };

   taylor_series_sin_cos_exp_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_x_value     (req_x_value),
      .rsp_valid       (rsp_valid),
      .rsp_partial_sum (rsp_partial_sum),
      .rsp_term_index  (rsp_term_index),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Term magnitude times |x|, rounded back to the fraction width and clamped.
   // The product is built from two halves so that it never leaves 64 bits.
   function automatic longint unsigned scale_by_x(input longint unsigned m,
                                                  input longint unsigned ax);
      longint unsigned lo, hi, r;
      lo = (m & 64'hFFFF_FFFF) * ax + (64'd1 << (FRAC_BITS - 1));
      hi = (m >> 32) * ax;
      r  = (hi << (32 - FRAC_BITS)) + (lo >> FRAC_BITS);
      return (r > MAG_LIMIT) ? MAG_LIMIT : r;
   endfunction

   // Division rounded to nearest, half up.
   function automatic longint unsigned round_div(input longint unsigned m,
                                                 input longint unsigned d);
      return (m + d / 2) / d;
   endfunction

   // Works out every partial sum of one argument and queues it.
   function automatic void sum_series(input logic [1:0] func, input logic [X_W-1:0] x,
                                      input bit typed, input logic [SUM_W-1:0] first_sum);
      longint unsigned ax, mag, n, stp, d, i;
      longint          acc;
      logic            xneg, neg;
      sum_beat_type    beat;
      if (func == FUNC_BAD)
         return;
      xneg = x[X_W-1];
      ax   = xneg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
      // Sine and cosine fold the magnitude into the range up to 2 pi.
      if (func != FUNC_EXP && ax > TWO_PI_Q)
         ax -= TWO_PI_Q * ((ax - 1) / TWO_PI_Q);
      n = num_terms_cfg;
      if (n < 1)
         n = 1;
      if (n > MAX_TERMS)
         n = MAX_TERMS;
      stp = (func == FUNC_EXP) ? 1 : 2;
      if (func == FUNC_SIN) begin
         mag = ax;
         neg = xneg;
      end else begin
         mag = 64'd1 << FRAC_BITS;
         neg = 1'b0;
      end
      acc = 0;
      for (i = 1; i <= n; i += stp) begin
         if (i > 1) begin
            if (func == FUNC_EXP) begin
               mag = round_div(scale_by_x(mag, ax), i - 1);
               neg ^= xneg;
            end else begin
               d   = (func == FUNC_SIN) ? (i - 1) * i : (i - 2) * (i - 1);
               mag = round_div(scale_by_x(scale_by_x(mag, ax), ax), d);
               neg = ~neg;
            end
         end
         acc += neg ? -longint'(mag) : longint'(mag);
         if (acc > SUM_HI)
            acc = SUM_HI;
         if (acc < SUM_LO)
            acc = SUM_LO;
         beat.sum  = (typed && i == 1) ? first_sum : acc[SUM_W-1:0];
         beat.idx  = i[IDX_W-1:0];
         beat.last = (i + stp > n);
         pending_sums.push_back(beat);
      end
   endfunction

   // Arguments: full range, small values, values next to 2 pi, and extremes.
   function automatic logic [X_W-1:0] random_arg();
      logic [X_W-1:0] mag;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 9: return $urandom;
         4, 5, 6: mag = $urandom & 32'h3FFF_FFFF;
         7: mag = 32'(TWO_PI_Q) + $urandom_range(0, 8) - 32'd4;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0001;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Mostly back to back or short gaps, now and then a long one.
   function automatic int unsigned gap_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 40);
      return $urandom_range(60, 300);
   endfunction

   // Presents one argument, waits until the block takes it, then queues its sums.
   task automatic send_arg(input logic [1:0] func, input logic [X_W-1:0] x,
                           input bit typed, input logic [SUM_W-1:0] first_sum);
      start       <= 1'b1;
      req_type    <= func;
      req_x_value <= x;
      do
         @(posedge clock);
      while (busy);
      sum_series(func, x, typed, first_sum);
   endtask

   // Holds start low until every queued sum is out and the block has settled.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_sums.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Gap after an accepted argument, sometimes a full drain.
   task automatic pace(input bit no_gaps);
      int unsigned gap;
      if ($urandom_range(0, 24) == 0) begin
         wait_idle();
      end else begin
         gap = no_gaps ? 0 : gap_cycles();
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_num_terms(input logic [IDX_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      num_terms_cfg  = value;
   endtask

   // Every result beat is matched against the oldest queued sum.
   always @(posedge clock) begin : check_beats
      sum_beat_type due;
      if (!reset && rsp_valid) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected beat: partial_sum %h term_index %0d last %b",
                   rsp_partial_sum, rsp_term_index, rsp_last);
            error_count++;
         end else begin
            due = pending_sums.pop_front();
            if (rsp_partial_sum !== due.sum) begin
               $error("partial_sum mismatch: expected %h, actual %h", due.sum,
                      rsp_partial_sum);
               error_count++;
            end
            if (rsp_term_index !== due.idx) begin
               $error("term_index mismatch: expected %0d, actual %0d", due.idx,
                      rsp_term_index);
               error_count++;
            end
            if (rsp_last !== due.last) begin
               $error("last mismatch: expected %b, actual %b", due.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Directed arguments at the reset term count, then random phases over several counts.
   initial begin : stimulus
      int unsigned phase_terms, counted, quota;
      logic [1:0]  func;
      bit          no_gaps;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_args[r]) begin
         send_arg(directed_args[r].func, directed_args[r].x, directed_args[r].typed,
                  directed_args[r].first_sum);
         pace(1'b0);
      end
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         phase_terms = (p < FIXED_PHASES) ? fixed_terms[p] : $urandom_range(1, 24);
         write_num_terms(7'(phase_terms));
         // Long series are slow, so those phases stay short.
         quota   = (phase_terms >= MAX_TERMS) ? 5 : 15;
         no_gaps = ($urandom_range(0, 3) == 0);
         counted = 0;
         while (counted < quota) begin
            func = ($urandom_range(0, 9) == 0) ? FUNC_BAD : 2'($urandom_range(0, 2));
            send_arg(func, random_arg(), 1'b0, '0);
            if (func != FUNC_BAD)
               counted++;
            pace(no_gaps);
         end
      end
      wait_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
